[hw/rtl/tbsd_pkg.sv]
// Package for the threshold bit-string deframer.
// Holds the shared types, register indexes and framing constants.
// No dependencies.
`timescale 1ns / 1ps

package tbsd_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned MaxLenW   = 9;
  localparam int unsigned ByteW     = 8;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_BIT_THRESHOLD = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_MAX_LENGTH    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [63:0]        THRESHOLD_RESET  = 64'd40000000000000;
  localparam logic [MaxLenW-1:0] MAX_LENGTH_RESET = 9'd128;

  // Framing bytes.
  localparam logic [ByteW-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [ByteW-1:0] END_BYTE  = 8'h00;

  // Deframer phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] char_code;
    logic             has_char;
    logic             last;
  } result_t;

endpackage

[hw/rtl/tbsd_cfg_regs.sv]
// Configuration registers of the threshold bit-string deframer.
// Depends on tbsd_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module tbsd_cfg_regs import tbsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CfgIndexW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic [COUNT_BITS-1:0] threshold_o,
  output logic [MaxLenW-1:0]    max_length_o
);

  logic [COUNT_BITS-1:0] threshold_q, threshold_d;
  logic [MaxLenW-1:0]    max_length_q, max_length_d;
  logic [63:0]           data_ext;

  // Write data widened, then cut to the count width.
  assign data_ext = {{(64 - CfgDataW){1'b0}}, cfg_data_i};

  // Register write decode.
  always_comb begin
    threshold_d  = threshold_q;
    max_length_d = max_length_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BIT_THRESHOLD: threshold_d  = data_ext[COUNT_BITS-1:0];
        CFG_MAX_LENGTH:    max_length_d = cfg_data_i[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RESET[COUNT_BITS-1:0];
      max_length_q <= MAX_LENGTH_RESET;
    end else begin
      threshold_q  <= threshold_d;
      max_length_q <= max_length_d;
    end
  end

  assign threshold_o  = threshold_q;
  assign max_length_o = max_length_q;

endmodule

[hw/rtl/tbsd_core.sv]
// Bit decision and framing state machine of the threshold bit-string deframer.
// Depends on tbsd_pkg for the phase enum, framing bytes and result struct.
`timescale 1ns / 1ps

module tbsd_core import tbsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [COUNT_BITS-1:0] threshold_i,
  input  logic [MaxLenW-1:0]    max_length_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [2:0]       index_q, index_d;
  logic [ByteW-1:0] count_q, count_d;

  logic             bit_val;
  logic [ByteW-1:0] shift_new;
  logic             byte_done;
  logic [ByteW-1:0] char_limit;
  logic [ByteW-1:0] count_inc;
  logic             at_limit;

  // A short bit period count decodes as a one.
  assign bit_val   = (count_i < threshold_i);
  assign shift_new = shift_q | (ByteW'(bit_val) << index_q);
  assign byte_done = (index_q == 3'd7);

  // Characters allowed per string: max_length - 1, clamped to 0 .. 255.
  always_comb begin
    if (max_length_i[MaxLenW-1]) begin
      char_limit = 8'd255;
    end else if (max_length_i < 9'd2) begin
      char_limit = 8'd0;
    end else begin
      char_limit = 8'(max_length_i - 9'd1);
    end
  end

  assign count_inc = count_q + 8'd1;
  assign at_limit  = (count_inc == 8'd0) || (count_inc >= char_limit);

  // Next state.
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    index_d = index_q;
    count_d = count_q;
    if (step_i) begin
      unique case (phase_q)
        PH_SYNC, PH_BODY: begin
          if (byte_done) begin
            shift_d = '0;
            index_d = '0;
            if (phase_q == PH_SYNC) begin
              if (shift_new == SYNC_BYTE) begin
                count_d = '0;
                phase_d = (char_limit == 8'd0) ? PH_HUNT : PH_BODY;
              end else if (shift_new == END_BYTE) begin
                phase_d = PH_HUNT;
              end
            end else begin
              if (shift_new == END_BYTE || at_limit) begin
                phase_d = PH_HUNT;
                count_d = '0;
              end else begin
                count_d = count_inc;
              end
            end
          end else begin
            shift_d = shift_new;
            index_d = index_q + 3'd1;
          end
        end
        default: begin
          // Hunting, and the unused phase code acts as hunting.
          phase_d = PH_HUNT;
          if (bit_val) begin
            phase_d = PH_SYNC;
            shift_d = '0;
            index_d = '0;
          end
        end
      endcase
    end
  end

  // Result of the current step.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i && byte_done) begin
      unique case (phase_q)
        PH_SYNC: begin
          if (shift_new == SYNC_BYTE && char_limit == 8'd0) begin
            res_valid_o = 1'b1;
            res_o.last  = 1'b1;
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          if (shift_new == END_BYTE) begin
            res_o.last = 1'b1;
          end else begin
            res_o.char_code = shift_new;
            res_o.has_char  = 1'b1;
            res_o.last      = at_limit;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      shift_q <= '0;
      index_q <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      index_q <= index_d;
      count_q <= count_d;
    end
  end

endmodule

[hw/rtl/tbsd_out_reg.sv]
// Result register of the threshold bit-string deframer.
// Holds one result item until the receiver takes it. Depends on tbsd_pkg.
`timescale 1ns / 1ps

module tbsd_out_reg import tbsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // The register can take a new item when empty or when it is being drained.
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/threshold_bit_string_deframer_top.sv]
// Top level of the threshold bit-string deframer.
// Instantiates tbsd_cfg_regs, tbsd_core and tbsd_out_reg; uses tbsd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / activity_count_i): one item per
//   bit period, the activity count of that period. Counts below the
//   bit_threshold register decode as a one bit.
//   Output channel (out_valid_o / out_ready_i): one result item per received
//   character and per terminator; the character at the length limit carries last.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   index 0 is bit_threshold, index 1 is max_length; always ready. Write only
//   while the block is idle.
// Timing:
//   An accepted item lands in the input register and is decoded once the
//   result register has room; a result it causes is then loaded into the
//   result register. One item per cycle is sustained while the receiver
//   keeps up, as the compare and next-state logic between the two is combinational.
//   When the receiver stalls, the result register holds its item and the
//   input register absorbs one more item before in_ready_o drops.
// Reset: state returns to hunting for the start bit, both registers empty,
//   configuration registers take their reset values.
`timescale 1ns / 1ps

module threshold_bit_string_deframer_top import tbsd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COUNT_BITS-1:0] activity_count_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIndexW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ByteW-1:0]      char_code_o,
  output logic                  has_char_o,
  output logic                  last_o
);

  logic [COUNT_BITS-1:0] threshold;
  logic [MaxLenW-1:0]    max_length;
  logic                  in_valid_q, in_valid_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  out_space;
  logic                  step;
  logic                  res_valid;
  result_t               res;
  result_t               res_out;

  assign cfg_ready_o = 1'b1;

  tbsd_cfg_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .threshold_o (threshold),
    .max_length_o(max_length)
  );

  // Input register: the held item is decoded when the result register has room.
  assign step       = in_valid_q && out_space;
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    count_d    = count_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      count_d    = activity_count_i;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  tbsd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .count_i     (count_q),
    .threshold_i (threshold),
    .max_length_i(max_length),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tbsd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .space_o    (out_space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign char_code_o = res_out.char_code;
  assign has_char_o  = res_out.has_char;
  assign last_o      = res_out.last;

endmodule

[hw/rtl/tbsd_checker.sv]
// Port-level checker for the threshold bit-string deframer.
// Bound to threshold_bit_string_deframer_top; depends on tbsd_pkg.
`timescale 1ns / 1ps

module tbsd_checker import tbsd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] char_code_o,
  input logic             has_char_o,
  input logic             last_o
);

  // A result without a character carries a zero code.
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_char_o) |-> (char_code_o == END_BYTE))
    else $error("result without character has nonzero code");

  // A result without a character is only ever an end-of-string marker.
  a_nochar_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_char_o) |-> last_o)
    else $error("result without character is not marked last");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(char_code_o) && $stable(has_char_o) && $stable(last_o)))
    else $error("stalled result item changed");

endmodule

bind threshold_bit_string_deframer_top tbsd_checker u_tbsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .char_code_o(char_code_o),
  .has_char_o (has_char_o),
  .last_o     (last_o)
);

[test/threshold_bit_string_deframer_top_tb.sv]
// Testbench for threshold_bit_string_deframer_top: drives bit-period counts and register
// writes, predicts every result item in its own decoder and checks each output item.
// Depends on tbsd_pkg and the threshold_bit_string_deframer_top RTL.
`timescale 1ns / 1ps

module threshold_bit_string_deframer_top_tb;
  import tbsd_pkg::*;

  localparam int unsigned CountW       = 48;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomItems  = 1000;

  typedef logic [ByteW-1:0] byte_q_t[$];

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [CountW-1:0]    activity_count_i = '0;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic [ByteW-1:0]     char_code_o;
  logic                 has_char_o;
  logic                 last_o;

  // Shadow copy of the deframer state and its registers.
  phase_e               shadow_phase;
  logic [ByteW-1:0]     shadow_shift;
  logic [2:0]           shadow_idx;
  logic [7:0]           shadow_count;
  logic [CountW-1:0]    shadow_thr;
  logic [MaxLenW-1:0]   shadow_maxlen;

  result_t     pending_chars[$];
  int unsigned err_count  = 0;
  int unsigned bits_sent  = 0;
  int unsigned chars_seen = 0;
  int unsigned cfg_writes = 0;
  bit          idle_en    = 1'b1;
  bit          hold_req   = 1'b0;

  threshold_bit_string_deframer_top #(
    .COUNT_BITS(CountW)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .activity_count_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .char_code_o,
    .has_char_o,
    .last_o
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("timeout: %0d results still pending", pending_chars.size());
    $display("** threshold_bit_string_deframer_top: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 30) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Number of characters a string may carry under the current max_length.
  function automatic int unsigned char_limit();
    int unsigned n;
    n = (shadow_maxlen > 256) ? 256 : shadow_maxlen;
    return (n < 2) ? 0 : n - 1;
  endfunction

  // Decodes one bit period and queues the result item it causes, if any.
  task automatic decode_bit_period(input logic [CountW-1:0] cnt);
    logic             one;
    logic [ByteW-1:0] b;
    logic             done;
    result_t          r;
    one  = (cnt < shadow_thr);
    done = 1'b0;
    b    = '0;
    if (shadow_phase == PH_SYNC || shadow_phase == PH_BODY) begin
      shadow_shift = shadow_shift | (ByteW'(one) << shadow_idx);
      if (shadow_idx == 3'd7) begin
        b            = shadow_shift;
        shadow_shift = '0;
        shadow_idx   = '0;
        done         = 1'b1;
      end else begin
        shadow_idx = shadow_idx + 3'd1;
      end
    end else if (one) begin
      // Hunting: a one bit is the start bit.
      shadow_phase = PH_SYNC;
      shadow_shift = '0;
      shadow_idx   = '0;
    end else begin
      shadow_phase = PH_HUNT;
    end
    if (done && shadow_phase == PH_SYNC) begin
      if (b == SYNC_BYTE) begin
        shadow_count = '0;
        if (char_limit() == 0) begin
          shadow_phase = PH_HUNT;
          r = '{char_code: '0, has_char: 1'b0, last: 1'b1};
          pending_chars.push_back(r);
        end else begin
          shadow_phase = PH_BODY;
        end
      end else if (b == END_BYTE) begin
        shadow_phase = PH_HUNT;
      end
    end else if (done) begin
      if (b == END_BYTE) begin
        shadow_phase = PH_HUNT;
        shadow_count = '0;
        r = '{char_code: '0, has_char: 1'b0, last: 1'b1};
      end else begin
        shadow_count = shadow_count + 8'd1;
        if (shadow_count == 8'd0 || shadow_count >= char_limit()) begin
          shadow_phase = PH_HUNT;
          shadow_count = '0;
          r = '{char_code: b, has_char: 1'b1, last: 1'b1};
        end else begin
          r = '{char_code: b, has_char: 1'b1, last: 1'b0};
        end
      end
      pending_chars.push_back(r);
    end
  endtask

  function automatic logic [CountW-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CountW-1:0];
  endfunction

  // Picks a count that decodes as the wanted bit, often right at the threshold.
  function automatic logic [CountW-1:0] count_for(input logic one);
    logic [63:0] r;
    logic [63:0] span;
    int unsigned k;
    r = {$urandom, $urandom};
    k = $urandom_range(0, 5);
    if (one) begin
      if (shadow_thr == '0) return r[CountW-1:0];
      if (k == 0) return '0;
      if (k == 1) return shadow_thr - 1'b1;
      return CountW'(r % 64'(shadow_thr));
    end
    if (k == 0) return COUNT_MAX;
    if (k == 1) return shadow_thr;
    span = 64'(COUNT_MAX) - 64'(shadow_thr) + 64'd1;
    return CountW'(64'(shadow_thr) + r % span);
  endfunction

  // Offers one bit-period item and predicts it once accepted.
  task automatic send_count(input logic [CountW-1:0] cnt);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    activity_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    decode_bit_period(cnt);
    bits_sent++;
  endtask

  task automatic send_bit(input logic one);
    send_count(count_for(one));
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    for (int i = 0; i < ByteW; i++) send_bit(b[i]);
  endtask

  // Start bit, sync byte, body and an optional terminator.
  task automatic send_frame(input byte_q_t body, input bit with_end);
    send_bit(1'b1);
    send_byte(SYNC_BYTE);
    foreach (body[i]) send_byte(body[i]);
    if (with_end) send_byte(END_BYTE);
  endtask

  // Lets the block run dry so that registers may be written.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the channel idles after it.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_BIT_THRESHOLD) shadow_thr = data[CountW-1:0];
    else shadow_maxlen = data[MaxLenW-1:0];
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Receiver: random ready bursts, plus one long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  // Compares each accepted result item with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result code=%02h has=%b last=%b",
                                  char_code_o, has_char_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (char_code_o !== want.char_code)
          report_mismatch($sformatf("char_code %02h, expected %02h",
                                    char_code_o, want.char_code));
        if (has_char_o !== want.has_char)
          report_mismatch($sformatf("has_char %b, expected %b", has_char_o, want.has_char));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
      end
    end
  end

  // Reset values, with counts at the top of the field and at the reset threshold.
  task automatic test_reset_values();
    send_count(COUNT_MAX);
    send_count(THRESHOLD_RESET[CountW-1:0]);
    send_frame('{8'h4F, 8'h4B}, 1'b1);
    settle();
  endtask

  // Threshold at zero decodes nothing as one; at the maximum only the top count is zero.
  task automatic test_threshold_extremes();
    write_reg(CFG_BIT_THRESHOLD, '0);
    send_count('0);
    send_count(COUNT_MAX);
    repeat (6) send_count(rand48());
    settle();
    write_reg(CFG_BIT_THRESHOLD, {CfgDataW{1'b1}});
    send_count(COUNT_MAX);
    send_frame('{8'hFF, 8'h01}, 1'b1);
    settle();
    write_reg(CFG_BIT_THRESHOLD, THRESHOLD_RESET[CfgDataW-1:0]);
  endtask

  // A nonzero non-sync byte is followed by another byte; a zero byte restarts the hunt.
  task automatic test_sync_search();
    send_bit(1'b1);
    send_byte(8'h55);
    send_byte(SYNC_BYTE);
    send_byte(8'h41);
    send_byte(END_BYTE);
    send_bit(1'b1);
    send_byte(END_BYTE);
    send_bit(1'b0);
    send_frame('{8'hAA, 8'h80}, 1'b1);
    settle();
  endtask

  // Limits of 0 and 1 end the string at the sync byte; 2 and 3 cut it short.
  task automatic test_small_limits();
    for (int n = 0; n < 4; n++) begin
      write_reg(CFG_MAX_LENGTH, CfgDataW'(n));
      send_frame('{8'h7E, 8'h33, 8'h21}, 1'b0);
      send_byte(END_BYTE);
      settle();
    end
  endtask

  // Lowering the limit in the middle of a string ends it at the next character.
  task automatic test_limit_lowered();
    write_reg(CFG_MAX_LENGTH, CfgDataW'(MAX_LENGTH_RESET));
    send_frame('{8'h10, 8'h20, 8'h30, 8'h40}, 1'b0);
    settle();
    write_reg(CFG_MAX_LENGTH, CfgDataW'(2));
    send_byte(8'h50);
    send_byte(8'h60);
    settle();
  endtask

  // A max_length above 256 acts as 256; the upper data bits are dropped.
  task automatic test_full_length();
    byte_q_t body;
    write_reg(CFG_MAX_LENGTH, {CfgDataW{1'b1}});
    for (int i = 0; i < 258; i++) body.push_back(ByteW'($urandom_range(1, 255)));
    send_frame(body, 1'b0);
    settle();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    byte_q_t body;
    write_reg(CFG_MAX_LENGTH, CfgDataW'(256));
    for (int i = 0; i < 40; i++) body.push_back(ByteW'($urandom_range(1, 255)));
    hold_req = 1'b1;
    send_frame(body, 1'b1);
    settle();
  endtask

  // Random phases of register settings, mostly well-formed frames plus noise.
  task automatic random_phase(input int unsigned n_frames);
    byte_q_t     body;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       write_reg(CFG_BIT_THRESHOLD, '0);
      1:       write_reg(CFG_BIT_THRESHOLD, {CfgDataW{1'b1}});
      2, 3:    write_reg(CFG_BIT_THRESHOLD, rand48());
      4:       write_reg(CFG_BIT_THRESHOLD, CfgDataW'($urandom_range(1, 1000)));
      default: write_reg(CFG_BIT_THRESHOLD, THRESHOLD_RESET[CfgDataW-1:0]);
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       write_reg(CFG_MAX_LENGTH, CfgDataW'($urandom_range(0, 1)));
      1:       write_reg(CFG_MAX_LENGTH, {rand48()} & ~CfgDataW'(9'h1FF) | CfgDataW'(256));
      2:       write_reg(CFG_MAX_LENGTH, rand48());
      3, 4, 5: write_reg(CFG_MAX_LENGTH, CfgDataW'($urandom_range(2, 8)));
      default: write_reg(CFG_MAX_LENGTH, CfgDataW'($urandom_range(9, 128)));
    endcase
    for (int f = 0; f < n_frames; f++) begin
      body.delete();
      repeat ($urandom_range(0, 3)) send_bit(1'b0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise: random counts with no framing.
        repeat ($urandom_range(4, 24)) send_count(rand48());
      end else begin
        if (pick == 1) begin
          send_bit(1'b1);
          send_byte(ByteW'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 10)) begin
          body.push_back(($urandom_range(0, 15) == 0) ? END_BYTE
                                                       : ByteW'($urandom_range(1, 255)));
        end
        send_frame(body, $urandom_range(0, 4) != 0);
      end
    end
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    stop_at = bits_sent + RandomItems;
    while (bits_sent < stop_at) random_phase($urandom_range(1, 4));
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    write_reg(CFG_BIT_THRESHOLD, THRESHOLD_RESET[CfgDataW-1:0]);
    write_reg(CFG_MAX_LENGTH, CfgDataW'(6));
    repeat (4) begin
      send_frame('{ByteW'($urandom_range(1, 255)), ByteW'($urandom_range(1, 255)),
                   ByteW'($urandom_range(1, 255))}, 1'b1);
    end
    send_frame('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06}, 1'b0);
    settle();
  endtask

  initial begin
    shadow_phase  = PH_HUNT;
    shadow_shift  = '0;
    shadow_idx    = '0;
    shadow_count  = '0;
    shadow_thr    = THRESHOLD_RESET[CountW-1:0];
    shadow_maxlen = MAX_LENGTH_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_threshold_extremes();
    test_sync_search();
    test_small_limits();
    test_limit_lowered();
    test_full_length();
    test_backpressure();
    test_random_frames();
    test_steady_stream();

    repeat (SettleCycles) @(posedge clk_i);
    $display("sent %0d bit periods and %0d register writes, checked %0d result items",
             bits_sent, cfg_writes, chars_seen);
    $display("covered threshold and length extremes, sync search, limits and a long stall");
    if (err_count == 0) begin
      $display("** threshold_bit_string_deframer_top: PASSED **");
    end else begin
      $display("%0d mismatches", err_count);
      $display("** threshold_bit_string_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule

[threshold_bit_string_deframer_top.f]
hw/rtl/tbsd_pkg.sv
hw/rtl/tbsd_cfg_regs.sv
hw/rtl/tbsd_core.sv
hw/rtl/tbsd_out_reg.sv
hw/rtl/threshold_bit_string_deframer_top.sv
hw/rtl/tbsd_checker.sv
test/threshold_bit_string_deframer_top_tb.sv
